/* hw/rtl/pgnl_pkg.sv */
package pgnl_pkg;

	localparam int POS_BITS_DEF = 16;

	typedef enum logic [2:0] {
		LX_OUT   = 3'd0,
		LX_STR   = 3'd1,
		LX_BRACE = 3'd2,
		LX_SEMI  = 3'd3,
		LX_SYM   = 3'd4
	} lex_state_t;

	typedef enum logic [1:0] {
		K_VALUE = 2'd0,
		K_TOKEN = 2'd1,
		K_ERROR = 2'd2
	} kind_t;

	localparam logic [2:0] TT_OPEN = 3'd0;
	localparam logic [2:0] TT_CLOSE = 3'd1;
	localparam logic [2:0] TT_TAG_NAME = 3'd2;
	localparam logic [2:0] TT_TAG_VALUE = 3'd3;
	localparam logic [2:0] TT_COMMENT = 3'd4;
	localparam logic [2:0] TT_MOVE_NUM = 3'd5;
	localparam logic [2:0] TT_MOVE = 3'd6;
	localparam logic [2:0] TT_RESULT = 3'd7;

	localparam logic [1:0] EC_BAD_CHAR = 2'd0;
	localparam logic [1:0] EC_BAD_START = 2'd1;
	localparam logic [1:0] EC_UNKNOWN = 2'd2;
	localparam logic [1:0] EC_NO_TERM = 2'd3;

	localparam logic [4:0] MV_DEAD = 5'd31;
	localparam logic [3:0] RS_DEAD = 4'd15;
	localparam logic [1:0] NM_DEAD = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value_char;
		logic [2:0]  token_type;
		logic [1:0]  error_code;
		logic [15:0] line_number;
		logic [15:0] column_number;
		logic        last;
	} out_item_t;

	// symbol classification state
	typedef struct packed {
		logic [4:0] mv;
		logic [3:0] rs;
		logic [1:0] nm;
		logic       word;
	} sym_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || is_alpha(c) || c == "_";
	endfunction

	function automatic logic is_sym_char(input logic [7:0] c);
		return is_word(c) || c == "+" || c == "-" || c == "." || c == ":" || c == "#"
			|| c == "=" || c == "/";
	endfunction

	function automatic logic is_piece(input logic [7:0] c);
		return c == "B" || c == "K" || c == "N" || c == "P" || c == "Q" || c == "R";
	endfunction

	function automatic logic is_file(input logic [7:0] c);
		return c >= "a" && c <= "h";
	endfunction

	function automatic logic is_rank(input logic [7:0] c);
		return c >= "1" && c <= "8";
	endfunction

	function automatic logic is_check(input logic [7:0] c);
		return c == "+" || c == "#";
	endfunction

	function automatic logic [4:0] move_next(input logic [4:0] s, input logic [7:0] c);
		logic [4:0] n;
		n = MV_DEAD;
		case (s)
			5'd0: begin
				if (is_piece(c)) n = 5'd1;
				else if (is_file(c)) n = 5'd2;
				else if (is_rank(c)) n = 5'd4;
				else if (c == "x") n = 5'd5;
				else if (c == "O") n = 5'd11;
			end
			5'd1: begin
				if (is_file(c)) n = 5'd2;
				else if (is_rank(c)) n = 5'd4;
				else if (c == "x") n = 5'd5;
			end
			5'd2: begin
				if (is_rank(c)) n = 5'd3;
				else if (is_file(c)) n = 5'd6;
				else if (c == "x") n = 5'd5;
			end
			5'd3: begin
				if (is_file(c)) n = 5'd6;
				else if (c == "x") n = 5'd5;
				else if (c == "=") n = 5'd8;
				else if (is_check(c)) n = 5'd10;
			end
			5'd4: begin
				if (c == "x") n = 5'd5;
				else if (is_file(c)) n = 5'd6;
			end
			5'd5: if (is_file(c)) n = 5'd6;
			5'd6: if (is_rank(c)) n = 5'd7;
			5'd7: begin
				if (c == "=") n = 5'd8;
				else if (is_check(c)) n = 5'd10;
			end
			5'd8: if (is_piece(c)) n = 5'd9;
			5'd9: if (is_check(c)) n = 5'd10;
			5'd11: if (c == "-") n = 5'd12;
			5'd12: if (c == "O") n = 5'd13;
			5'd13: if (c == "-") n = 5'd14;
			5'd14: if (c == "O") n = 5'd15;
			default: n = MV_DEAD;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] result_next(input logic [3:0] s, input logic [7:0] c);
		logic [3:0] n;
		n = RS_DEAD;
		case (s)
			4'd0: begin
				if (c == "0") n = 4'd1;
				else if (c == "1") n = 4'd4;
			end
			4'd1: if (c == "-") n = 4'd2;
			4'd2: if (c == "1") n = 4'd3;
			4'd4: begin
				if (c == "-") n = 4'd5;
				else if (c == "/") n = 4'd7;
			end
			4'd5: if (c == "0") n = 4'd6;
			4'd7: if (c == "2") n = 4'd8;
			4'd8: if (c == "-") n = 4'd9;
			4'd9: if (c == "1") n = 4'd10;
			4'd10: if (c == "/") n = 4'd11;
			4'd11: if (c == "2") n = 4'd12;
			default: n = RS_DEAD;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] number_next(input logic [1:0] s, input logic [7:0] c);
		logic [1:0] n;
		n = NM_DEAD;
		case (s)
			2'd0: if (is_digit(c)) n = 2'd1;
			2'd1: begin
				if (is_digit(c)) n = 2'd1;
				else if (c == ".") n = 2'd2;
			end
			2'd2: if (c == ".") n = 2'd2;
			default: n = NM_DEAD;
		endcase
		return n;
	endfunction

	function automatic sym_t feed(input sym_t s, input logic [7:0] c);
		sym_t n;
		n.mv = move_next(s.mv, c);
		n.rs = result_next(s.rs, c);
		n.nm = number_next(s.nm, c);
		n.word = s.word & is_word(c);
		return n;
	endfunction

endpackage

/* hw/rtl/pgnl_if.sv */
interface pgnl_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/pgnl_out_queue.sv */
// Holds up to four result items; a byte produces at most two.
module pgnl_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_count,
	input  pgnl_pkg::out_item_t wr_item0,
	input  pgnl_pkg::out_item_t wr_item1,
	output logic                has_room,
	pgnl_if.source              dout
);
	import pgnl_pkg::*;

	out_item_t  slot_q [4];
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] push_n;

	assign pop = dout.valid && dout.ready;
	assign dout.valid = cnt_q != 3'd0;
	assign dout.payload = slot_q[rd_q];
	assign push_n = wr_en ? {1'b0, wr_count} : 3'd0;
	// room for two more after this cycle's push and pop
	assign has_room = (cnt_q + push_n) <= (3'd2 + {2'b00, pop});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 2'd1;
			wr_q <= wr_q + push_n[1:0];
			cnt_q <= cnt_q + push_n - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_count != 2'd0) slot_q[wr_q] <= wr_item0;
		if (wr_en && wr_count == 2'd2) slot_q[wr_q + 2'd1] <= wr_item1;
	end
endmodule

/* hw/rtl/pgn_lexer_unit.sv */
// channel | dir | payload
// din     | in  | in_byte, end_of_text
// dout    | out | kind, value_char, token_type, error_code, line_number,
//         |     | column_number, last
// One byte per cycle: the byte is registered, decoded by shallow logic and its
// zero to two results pushed into a four-entry output queue; the first result
// can leave in the cycle after the byte is registered. Input stalls only when the
// queue, after this cycle's push and pop, could not take two more items. Reset
// clears lexer state and queue; after an error the block takes bytes and drops
// them until reset.
module pgn_lexer_unit #(
	parameter int POS_BITS = pgnl_pkg::POS_BITS_DEF
) (
	input logic    clk,
	input logic    arst_n,
	pgnl_if.sink   din,
	pgnl_if.source dout
);
	import pgnl_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	logic          v_s1;
	in_item_t      it_s1;
	logic          room;

	lex_state_t    lx_q;
	logic          halt_q;
	logic          bs_q;
	logic [POS_BITS-1:0] line_q;
	logic [POS_BITS-1:0] col_q;
	sym_t          sym_q;

	lex_state_t    lx_n;
	logic          halt_n;
	logic          bs_n;
	logic [POS_BITS-1:0] line_n;
	logic [POS_BITS-1:0] col_n;
	sym_t          sym_n;
	logic [1:0]    cnt;
	out_item_t     r0;
	out_item_t     r1;

	assign din.ready = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= din.valid && din.ready;
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) it_s1 <= din.payload;
	end

	always_comb begin
		logic [7:0] c;
		logic       outside;
		logic [2:0] tt;
		logic       good;
		logic [POS_BITS-1:0] colx;
		logic [1:0] k [2];
		logic [7:0] vc [2];
		logic [2:0] tk [2];
		logic [1:0] ec [2];
		logic [15:0] ln [2];
		c = it_s1.in_byte;
		lx_n = lx_q;
		halt_n = halt_q;
		bs_n = bs_q;
		sym_n = sym_q;
		cnt = 2'd0;
		outside = 1'b0;
		tt = TT_OPEN;
		good = 1'b0;
		k[0] = K_VALUE; k[1] = K_VALUE;
		vc[0] = '0; vc[1] = '0;
		tk[0] = '0; tk[1] = '0;
		ec[0] = '0; ec[1] = '0;
		ln[0] = 16'(line_q); ln[1] = 16'(line_q);
		colx = (col_q < POS_MAX) ? col_q + POS_ONE : col_q;
		col_n = colx;
		line_n = line_q;

		if (v_s1 && !halt_q) begin
			if (!((c >= 8'h09 && c <= 8'h0D) || (c >= 8'h20 && c <= 8'h7E))) begin
				k[0] = K_ERROR; ec[0] = EC_BAD_CHAR; cnt = 2'd1; halt_n = 1'b1;
			end else begin
				case (lx_q)
					LX_STR: begin
						cnt = 2'd1;
						if (c == "\"" && !bs_q) begin
							k[0] = K_TOKEN; tk[0] = TT_TAG_VALUE; lx_n = LX_OUT;
						end else begin
							vc[0] = c; bs_n = (c == "\\") && !bs_q;
						end
					end
					LX_BRACE: begin
						cnt = 2'd1;
						if (c == "}") begin
							k[0] = K_TOKEN; tk[0] = TT_COMMENT; lx_n = LX_OUT;
						end else vc[0] = c;
					end
					LX_SEMI: begin
						cnt = 2'd1;
						if (c == 8'h0A) begin
							k[0] = K_TOKEN; tk[0] = TT_COMMENT; lx_n = LX_OUT;
						end else vc[0] = c;
					end
					LX_SYM: begin
						if (is_sym_char(c)) begin
							sym_n = feed(sym_q, c); vc[0] = c; cnt = 2'd1;
						end else begin
							good = 1'b1;
							if (sym_q.rs == 4'd3 || sym_q.rs == 4'd6 || sym_q.rs == 4'd12)
								tt = TT_RESULT;
							else if (sym_q.nm == 2'd2) tt = TT_MOVE_NUM;
							else if (sym_q.mv == 5'd3 || sym_q.mv == 5'd7 || sym_q.mv == 5'd9
								|| sym_q.mv == 5'd10 || sym_q.mv == 5'd13
								|| sym_q.mv == 5'd15) tt = TT_MOVE;
							else if (sym_q.word) tt = TT_TAG_NAME;
							else good = 1'b0;
							cnt = 2'd1;
							if (good) begin
								k[0] = K_TOKEN; tk[0] = tt; lx_n = LX_OUT; outside = 1'b1;
							end else begin
								k[0] = K_ERROR; ec[0] = EC_UNKNOWN; halt_n = 1'b1;
							end
						end
					end
					default: begin
						lx_n = LX_OUT; outside = 1'b1;
					end
				endcase
				if (outside) begin
					// reprocess the byte as outside any lexeme, into slot cnt
					if (c == "[" || c == "]" || c == "*") begin
						k[cnt[0]] = K_TOKEN; vc[cnt[0]] = c;
						tk[cnt[0]] = (c == "[") ? TT_OPEN : (c == "]") ? TT_CLOSE : TT_RESULT;
						cnt = cnt + 2'd1;
					end else if (c == "\"") begin
						lx_n = LX_STR; bs_n = 1'b0;
					end else if (c == "{") lx_n = LX_BRACE;
					else if (c == ";") lx_n = LX_SEMI;
					else if (is_digit(c) || is_alpha(c)) begin
						lx_n = LX_SYM;
						sym_n = feed('{mv: 5'd0, rs: 4'd0, nm: 2'd0, word: 1'b1}, c);
						k[cnt[0]] = K_VALUE; vc[cnt[0]] = c;
						cnt = cnt + 2'd1;
					end else if (!((c >= 8'h09 && c <= 8'h0D) || c == " ")) begin
						k[cnt[0]] = K_ERROR; ec[cnt[0]] = EC_BAD_START;
						cnt = cnt + 2'd1; halt_n = 1'b1;
					end
				end
			end
			if (!halt_n && c == 8'h0A) begin
				if (line_q < POS_MAX) line_n = line_q + POS_ONE;
				col_n = '0;
			end
			if (!halt_n && it_s1.end_of_text) begin
				if (lx_n != LX_OUT) begin
					k[cnt[0]] = K_ERROR; ec[cnt[0]] = EC_NO_TERM;
					vc[cnt[0]] = '0; tk[cnt[0]] = '0;
					ln[cnt[0]] = 16'(line_n);
					cnt = cnt + 2'd1; halt_n = 1'b1;
				end else begin
					line_n = POS_ONE; col_n = '0;
				end
			end
		end else begin
			col_n = col_q;
		end

		r0 = '{kind: k[0], value_char: vc[0], token_type: tk[0], error_code: ec[0],
			line_number: ln[0], column_number: 16'(colx), last: cnt == 2'd1};
		r1 = '{kind: k[1], value_char: vc[1], token_type: tk[1], error_code: ec[1],
			line_number: ln[1], column_number: 16'(colx), last: 1'b1};
		// error at end of text reports the position after a line feed
		if (cnt == 2'd1 && k[0] == K_ERROR && ec[0] == EC_NO_TERM && c == 8'h0A)
			r0.column_number = '0;
		if (cnt == 2'd2 && k[1] == K_ERROR && ec[1] == EC_NO_TERM && c == 8'h0A)
			r1.column_number = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= LX_OUT;
			halt_q <= 1'b0;
			bs_q <= 1'b0;
			line_q <= POS_ONE;
			col_q <= '0;
			sym_q <= '{mv: 5'd0, rs: 4'd0, nm: 2'd0, word: 1'b1};
		end else begin
			lx_q <= lx_n;
			halt_q <= halt_n;
			bs_q <= bs_n;
			line_q <= line_n;
			col_q <= col_n;
			sym_q <= sym_n;
		end
	end

	pgnl_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (v_s1),
		.wr_count (cnt),
		.wr_item0 (r0),
		.wr_item1 (r1),
		.has_room (room),
		.dout     (dout)
	);
endmodule
